// File: rtl/core/assert_macros.svh
// assertion macros included by point_stride_range_gate_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/psrg_pkg.sv
// types and constants of the point stride range gate
package psrg_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int STRIDE_W    = 8;
  localparam int RANGE_W     = 16;
  localparam int DIST_W      = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_STRIDE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_RANGE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_RANGE = 2'd2;

  localparam logic [STRIDE_W-1:0] STRIDE_RST    = 8'd8;
  localparam logic [RANGE_W-1:0]  MIN_RANGE_RST = 16'd300;
  localparam logic [RANGE_W-1:0]  MAX_RANGE_RST = 16'd4000;

  localparam int TUSER_W         = 2;
  localparam int TUSER_FINITE    = 0;
  localparam int TUSER_FRAME_BEG = 1;

  localparam int SQ_STEPS = 3;

  typedef enum logic [1:0] {
    SEL_X = 2'd0,
    SEL_Y = 2'd1,
    SEL_Z = 2'd2
  } coord_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_LOAD,
    ST_ROOT,
    ST_CHECK
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       mult_en;
    coord_sel_t mult_sel;
    logic       acc_en;
    logic       root_load;
    logic       root_step;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic keep;
    logic finite;
    logic in_range;
    logic out_free;
  } ctrl_status_t;

endpackage

// File: rtl/core/psrg_ctrl.sv
// controller state machine: accept, square, root and result handoff sequencing
module psrg_ctrl #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  psrg_pkg::ctrl_status_t status,
  output psrg_pkg::ctrl_cmd_t    cmd,
  output psrg_pkg::state_t       state
);

  localparam int CNT_W = $clog2(COORD_BITS);

  psrg_pkg::state_t state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psrg_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    s_tready      = 1'b0;
    cmd           = '0;
    cmd.mult_sel  = psrg_pkg::SEL_X;
    unique case (state)
      psrg_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (status.keep && status.finite) begin
            state_next = psrg_pkg::ST_SQUARE;
            cnt_next   = '0;
          end
        end
      end
      psrg_pkg::ST_SQUARE: begin
        cmd.mult_en = (cnt < CNT_W'(psrg_pkg::SQ_STEPS));
        cmd.acc_en  = (cnt != '0);
        case (cnt[1:0])
          2'd1:    cmd.mult_sel = psrg_pkg::SEL_Y;
          2'd2:    cmd.mult_sel = psrg_pkg::SEL_Z;
          default: cmd.mult_sel = psrg_pkg::SEL_X;
        endcase
        if (cnt == CNT_W'(psrg_pkg::SQ_STEPS)) begin
          state_next = psrg_pkg::ST_LOAD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      psrg_pkg::ST_LOAD: begin
        cmd.root_load = 1'b1;
        cnt_next      = '0;
        state_next    = psrg_pkg::ST_ROOT;
      end
      psrg_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt == CNT_W'(COORD_BITS - 1)) begin
          state_next = psrg_pkg::ST_CHECK;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      psrg_pkg::ST_CHECK: begin
        if (!status.in_range) begin
          state_next = psrg_pkg::ST_IDLE;
        end else if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = psrg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = psrg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/psrg_datapath.sv
// datapath: stride phase, shared squaring multiplier, digit square root, output register
module psrg_datapath #(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  psrg_pkg::ctrl_cmd_t                   cmd,
  output psrg_pkg::ctrl_status_t                status,
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]     s_tdata,
  input  logic [psrg_pkg::TUSER_W-1:0]          s_tuser,
  input  logic [psrg_pkg::STRIDE_W-1:0]         stride_cfg,
  input  logic [psrg_pkg::RANGE_W-1:0]          min_range_mm,
  input  logic [psrg_pkg::RANGE_W-1:0]          max_range_mm,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((3*COORD_BITS+psrg_pkg::DIST_W+7)/8)*8-1:0] m_tdata
);

  localparam int CB    = COORD_BITS;
  localparam int SB    = 2 * COORD_BITS;
  localparam int RB    = COORD_BITS;
  localparam int CW    = (COORD_BITS > psrg_pkg::RANGE_W) ? COORD_BITS : psrg_pkg::RANGE_W;
  localparam int OUT_W = ((3*COORD_BITS+psrg_pkg::DIST_W+7)/8)*8;

  logic [psrg_pkg::STRIDE_W-1:0] phase;
  logic [psrg_pkg::STRIDE_W-1:0] phase_eff;
  logic [psrg_pkg::STRIDE_W-1:0] stride_eff;
  logic [psrg_pkg::STRIDE_W:0]   phase_inc;

  logic signed [CB-1:0]   cx, cy, cz;
  logic signed [CB-1:0]   mult_a;
  logic signed [SB-1:0]   sq_full;
  logic [SB-1:0]          prod;
  logic [SB-1:0]          sum;

  logic [SB-1:0]   rad;
  logic [RB+1:0]   rem;
  logic [RB-1:0]   root;
  logic [RB+3:0]   cand;
  logic [RB+3:0]   subv;
  logic [RB+3:0]   diff;

  logic [CW-1:0]   dist_ext;
  logic signed [CB-1:0] ox, oy, oz;
  logic [psrg_pkg::DIST_W-1:0] od;

  // stride keep test
  assign stride_eff = (stride_cfg == '0) ? psrg_pkg::STRIDE_W'(1) : stride_cfg;
  assign phase_eff  = s_tuser[psrg_pkg::TUSER_FRAME_BEG] ? '0 : phase;
  assign phase_inc  = {1'b0, phase_eff} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (cmd.accept) begin
      phase <= (phase_inc >= {1'b0, stride_eff}) ? '0 : phase_inc[psrg_pkg::STRIDE_W-1:0];
    end
  end

  // squares through one shared multiplier
  always_comb begin
    case (cmd.mult_sel)
      psrg_pkg::SEL_Y: mult_a = cy;
      psrg_pkg::SEL_Z: mult_a = cz;
      default:         mult_a = cx;
    endcase
  end

  assign sq_full = mult_a * mult_a;

  // restoring root, two radicand bits per step
  assign cand = {rem, rad[SB-1 -: 2]};
  assign subv = {2'b00, root, 2'b01};
  assign diff = cand - subv;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cx  <= s_tdata[CB-1:0];
      cy  <= s_tdata[2*CB-1:CB];
      cz  <= s_tdata[3*CB-1:2*CB];
      sum <= '0;
    end
    if (cmd.mult_en) begin
      prod <= unsigned'(sq_full);
    end
    if (cmd.acc_en) begin
      sum <= sum + prod;
    end
    if (cmd.root_load) begin
      rad  <= sum;
      rem  <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      rad <= {rad[SB-3:0], 2'b00};
      if (cand >= subv) begin
        rem  <= diff[RB+1:0];
        root <= {root[RB-2:0], 1'b1};
      end else begin
        rem  <= cand[RB+1:0];
        root <= {root[RB-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      ox <= cx;
      oy <= cy;
      oz <= cz;
      od <= dist_ext[psrg_pkg::DIST_W-1:0];
    end
  end

  assign dist_ext = CW'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = OUT_W'({od, oz, oy, ox});

  assign status.keep     = (phase_eff == '0);
  assign status.finite   = s_tuser[psrg_pkg::TUSER_FINITE];
  assign status.in_range = (dist_ext >= CW'(min_range_mm)) && (dist_ext <= CW'(max_range_mm));
  assign status.out_free = !m_tvalid || m_tready;

endmodule

// File: rtl/core/point_stride_range_gate_unit.sv
// point stride range gate: configuration registers, controller and datapath
// a kept finite point in range passes ST_SQUARE, ST_LOAD, ST_ROOT and ST_CHECK before m_tvalid rises
// input: a kept finite point holds s_tready low through these states, mostly in the square root
// that resolves one bit per cycle; any other point is dropped and the input stays ready
// a full output register stalls the controller before the result handoff
// reset (rst, synchronous): stride phase 0, registers 8 / 300 / 4000, no output pending
module point_stride_range_gate_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [psrg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [psrg_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // x_mm, y_mm, z_mm, zero fill
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]    s_tdata,
  // point_finite, frame_start
  input  logic [psrg_pkg::TUSER_W-1:0]         s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // out_x_mm, out_y_mm, out_z_mm, distance_mm, zero fill
  output logic [((3*COORD_BITS+psrg_pkg::DIST_W+7)/8)*8-1:0] m_tdata
);

  `include "assert_macros.svh"

  localparam int DIST_LO = 3 * COORD_BITS;

  logic [psrg_pkg::STRIDE_W-1:0] stride_cfg;
  logic [psrg_pkg::RANGE_W-1:0]  min_range_mm;
  logic [psrg_pkg::RANGE_W-1:0]  max_range_mm;

  psrg_pkg::ctrl_cmd_t    cmd;
  psrg_pkg::ctrl_status_t status;
  psrg_pkg::state_t       state;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride_cfg   <= psrg_pkg::STRIDE_RST;
      min_range_mm <= psrg_pkg::MIN_RANGE_RST;
      max_range_mm <= psrg_pkg::MAX_RANGE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        psrg_pkg::REG_STRIDE:    stride_cfg   <= cfg_data[psrg_pkg::STRIDE_W-1:0];
        psrg_pkg::REG_MIN_RANGE: min_range_mm <= cfg_data;
        psrg_pkg::REG_MAX_RANGE: max_range_mm <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  psrg_ctrl #(
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  psrg_datapath #(
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .stride_cfg   (stride_cfg),
    .min_range_mm (min_range_mm),
    .max_range_mm (max_range_mm),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
  );

  `ASSERT_CLK(a_load_slot_free, cmd.out_load |-> (!m_tvalid || m_tready), "output overwritten")
  `ASSERT_CLK(a_valid_from_load, $rose(m_tvalid) |-> $past(cmd.out_load), "result without load")
  `ASSERT_CLK(a_dist_in_range, m_tvalid |-> (m_tdata[DIST_LO +: psrg_pkg::DIST_W] >= min_range_mm
              && m_tdata[DIST_LO +: psrg_pkg::DIST_W] <= max_range_mm), "distance out of range")
  `ASSERT_CLK(a_load_from_check, cmd.out_load |-> state == psrg_pkg::ST_CHECK, "load outside check")

endmodule
